/* rtl/tta_pkg.sv */
// Shared request codes and storage word layouts for the tangent accumulator.
package tta_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TRI   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam int unsigned IDX_W = 12;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] tu;
    logic signed [15:0] tv;
  } vtx_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
  } sum_t;

endpackage

/* rtl/tta_in_if.sv */
// Request and result channel interfaces of the tangent accumulator.
interface tta_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [11:0]       vertex_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] tex_u;
  logic signed [15:0] tex_v;
  logic [11:0]       corner_a;
  logic [11:0]       corner_b;
  logic [11:0]       corner_c;

  modport source (output valid, req_type, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, req_type, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                corner_a, corner_b, corner_c, output ready);
endinterface

interface tta_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic               zero_length;

  modport source (output valid, tangent_x, tangent_y, tangent_z, zero_length, input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, zero_length, output ready);
endinterface

/* rtl/tta_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module tta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/triangle_tangent_accumulator.sv */
// Top level of the per-vertex tangent accumulator.
// Vertices live in one RAM, tangent sums (Q12.20, saturating) in a second. After reset a
// clearing pass zeroes the sum RAM, one entry a cycle, with no request taken. A triangle
// is done in steps: three vertex RAM reads, the edge and determinant products, three
// 57-step serial divisions for the tangent components, then a read-modify-write of each
// corner's sum through the sum RAM's single read and single write port. A read does
// one-bit-a-cycle normalization, three squares, a 32-step square root and three 57-step
// divisions on the shared divider. The result sits in an output register, so the next
// request is taken while it waits.
module triangle_tangent_accumulator #(
  parameter int VERTEX_DEPTH = 4096
) (
  input logic      clk,
  input logic      rst_n,
  tta_in_if.sink   in_ch,
  tta_out_if.source out_ch
);
  import tta_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_T_RA   = 5'd2;
  localparam logic [4:0] S_T_RB   = 5'd3;
  localparam logic [4:0] S_T_RC   = 5'd4;
  localparam logic [4:0] S_T_CAP  = 5'd5;
  localparam logic [4:0] S_T_DIFF = 5'd6;
  localparam logic [4:0] S_T_MDET = 5'd7;
  localparam logic [4:0] S_T_DET  = 5'd8;
  localparam logic [4:0] S_T_MNUM = 5'd9;
  localparam logic [4:0] S_T_NUM  = 5'd10;
  localparam logic [4:0] S_DIV    = 5'd11;
  localparam logic [4:0] S_T_QUO  = 5'd12;
  localparam logic [4:0] S_T_ARD  = 5'd13;
  localparam logic [4:0] S_T_AWR  = 5'd14;
  localparam logic [4:0] S_R_ISS  = 5'd15;
  localparam logic [4:0] S_R_CAP  = 5'd16;
  localparam logic [4:0] S_R_NORM = 5'd17;
  localparam logic [4:0] S_R_SQ   = 5'd18;
  localparam logic [4:0] S_R_SQRT = 5'd19;
  localparam logic [4:0] S_R_LD   = 5'd20;
  localparam logic [4:0] S_R_QUO  = 5'd21;
  localparam logic [4:0] S_R_OUT  = 5'd22;

  logic [4:0]    state_r;
  logic [1:0]    k_r;
  logic [1:0]    j_r;
  logic [5:0]    div_cnt_r;
  logic [AW-1:0] clr_addr_r;
  logic          out_valid_r;

  logic          req_tri_r;
  logic [AW-1:0] vi_r;
  logic [AW-1:0] cor_r [3];
  vtx_t          va_r, vb_r, vc_r;
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [16:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [33:0] p0_r, p1_r;
  logic signed [34:0] det_r;
  logic          neg_r;
  logic signed [31:0] t_r [3];
  logic [56:0]   div_quo_r;
  logic [36:0]   div_rem_r;
  logic [35:0]   div_den_r;
  logic          sg_r [3];
  logic [31:0]   m_r [3];
  logic [63:0]   sq_r, l2_r;
  logic [63:0]   sx_r, sres_r, sbit_r;
  logic signed [15:0] res_r [3];
  logic          res_zl_r;
  logic signed [15:0] o_x_r, o_y_r, o_z_r;
  logic          o_zl_r;

  logic          in_fire;
  logic          vi_ok, tri_ok;
  logic [AW-1:0] in_vi;
  logic          vtx_we;
  vtx_t          vtx_wdata, vtx_rdata;
  logic [AW-1:0] vtx_raddr;
  logic          sum_we;
  logic [AW-1:0] sum_waddr, sum_raddr;
  sum_t          sum_wdata, sum_rdata;
  logic signed [34:0] det_nxt, num_nxt;
  logic [34:0]   an, ad;
  logic [36:0]   rem_sh;
  logic          rem_ge;
  logic [31:0]   t_sat;
  logic [1:0]    sq_idx;
  logic [63:0]   sq_try;
  logic          sq_ge;
  logic [15:0]   q16;
  logic          out_free;

  function automatic logic in_range(input logic [IDX_W-1:0] i);
    return {{(32 - IDX_W){1'b0}}, i} < 32'(VERTEX_DEPTH);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_vi       = AW'(in_ch.vertex_index);
  assign vi_ok       = in_range(in_ch.vertex_index);
  assign tri_ok      = in_range(in_ch.corner_a) && in_range(in_ch.corner_b) &&
                       in_range(in_ch.corner_c);

  assign vtx_we    = in_fire && (in_ch.req_type == REQ_WRITE) && vi_ok;
  assign vtx_wdata = '{px: in_ch.pos_x, py: in_ch.pos_y, pz: in_ch.pos_z,
                       tu: in_ch.tex_u, tv: in_ch.tex_v};
  assign vtx_raddr = (state_r == S_T_RA) ? cor_r[0] :
                     (state_r == S_T_RB) ? cor_r[1] : cor_r[2];

  assign sum_we    = (state_r == S_CLR) || vtx_we || (state_r == S_T_AWR);
  assign sum_waddr = (state_r == S_CLR) ? clr_addr_r :
                     (state_r == S_T_AWR) ? cor_r[j_r] : in_vi;
  assign sum_raddr = (state_r == S_R_ISS) ? vi_r : cor_r[j_r];

  always_comb begin
    sum_wdata = '0;
    if (state_r == S_T_AWR) begin
      sum_wdata.sx = sat_add(sum_rdata.sx, t_r[0]);
      sum_wdata.sy = sat_add(sum_rdata.sy, t_r[1]);
      sum_wdata.sz = sat_add(sum_rdata.sz, t_r[2]);
    end
  end

  tta_ram #(.WIDTH($bits(vtx_t)), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
    .clk   (clk),
    .we    (vtx_we),
    .waddr (in_vi),
    .wdata (vtx_wdata),
    .raddr (vtx_raddr),
    .rdata (vtx_rdata)
  );

  tta_ram #(.WIDTH($bits(sum_t)), .DEPTH(VERTEX_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign det_nxt = $signed({p0_r[33], p0_r}) - $signed({p1_r[33], p1_r});
  assign num_nxt = det_nxt;
  assign an      = num_nxt[34] ? (~num_nxt + 35'd1) : num_nxt;
  assign ad      = det_r[34] ? (~det_r + 35'd1) : det_r;

  assign rem_sh = {div_rem_r[35:0], div_quo_r[56]};
  assign rem_ge = rem_sh >= {1'b0, div_den_r};

  always_comb begin
    if (neg_r) begin
      t_sat = (|div_quo_r[56:31]) ? 32'h8000_0000 : (~div_quo_r[31:0] + 32'd1);
    end else begin
      t_sat = (|div_quo_r[56:31]) ? 32'h7fff_ffff : div_quo_r[31:0];
    end
  end

  assign sq_idx = (j_r == 2'd3) ? 2'd0 : j_r;
  assign sq_try = sres_r + sbit_r;
  assign sq_ge  = sx_r >= sq_try;
  assign q16    = div_quo_r[15:0];
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      k_r         <= '0;
      j_r         <= '0;
      div_cnt_r   <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ((state_r == S_R_OUT) && out_free) || (out_valid_r && !out_ch.ready);
      case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(VERTEX_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.req_type)
              REQ_TRI:  if (tri_ok) state_r <= S_T_RA;
              REQ_READ: state_r <= vi_ok ? S_R_ISS : S_R_OUT;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_T_RA:   state_r <= S_T_RB;
        S_T_RB:   state_r <= S_T_RC;
        S_T_RC:   state_r <= S_T_CAP;
        S_T_CAP:  state_r <= S_T_DIFF;
        S_T_DIFF: state_r <= S_T_MDET;
        S_T_MDET: state_r <= S_T_DET;
        S_T_DET: begin
          k_r     <= '0;
          state_r <= (det_nxt == '0) ? S_IDLE : S_T_MNUM;
        end
        S_T_MNUM: state_r <= S_T_NUM;
        S_T_NUM: begin
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'd56) begin
            state_r <= req_tri_r ? S_T_QUO : S_R_QUO;
          end
        end
        S_T_QUO: begin
          k_r <= k_r + 2'd1;
          j_r <= '0;
          state_r <= (k_r == 2'd2) ? S_T_ARD : S_T_MNUM;
        end
        S_T_ARD: state_r <= S_T_AWR;
        S_T_AWR: begin
          j_r     <= j_r + 2'd1;
          state_r <= (j_r == 2'd2) ? S_IDLE : S_T_ARD;
        end
        S_R_ISS: state_r <= S_R_CAP;
        S_R_CAP: begin
          state_r <= (sum_rdata == '0) ? S_R_OUT : S_R_NORM;
        end
        S_R_NORM: begin
          j_r <= '0;
          if ((m_r[0][31:30] | m_r[1][31:30] | m_r[2][31:30]) != 2'b00) begin
            state_r <= S_R_SQ;
          end
        end
        S_R_SQ: begin
          j_r <= j_r + 2'd1;
          if (j_r == 2'd3) begin
            state_r <= S_R_SQRT;
          end
        end
        S_R_SQRT: begin
          k_r <= '0;
          if (sbit_r[0]) begin
            state_r <= S_R_LD;
          end
        end
        S_R_LD: begin
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_R_QUO: begin
          k_r     <= k_r + 2'd1;
          state_r <= (k_r == 2'd2) ? S_R_OUT : S_R_LD;
        end
        S_R_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_tri_r <= (in_ch.req_type == REQ_TRI);
          vi_r      <= in_vi;
          cor_r[0]  <= AW'(in_ch.corner_a);
          cor_r[1]  <= AW'(in_ch.corner_b);
          cor_r[2]  <= AW'(in_ch.corner_c);
          res_r[0]  <= '0;
          res_r[1]  <= '0;
          res_r[2]  <= '0;
          res_zl_r  <= 1'b1;
        end
      end
      S_T_RB:  va_r <= vtx_rdata;
      S_T_RC:  vb_r <= vtx_rdata;
      S_T_CAP: vc_r <= vtx_rdata;
      S_T_DIFF: begin
        e1_r[0] <= $signed({vb_r.px[15], vb_r.px}) - $signed({va_r.px[15], va_r.px});
        e1_r[1] <= $signed({vb_r.py[15], vb_r.py}) - $signed({va_r.py[15], va_r.py});
        e1_r[2] <= $signed({vb_r.pz[15], vb_r.pz}) - $signed({va_r.pz[15], va_r.pz});
        e2_r[0] <= $signed({vc_r.px[15], vc_r.px}) - $signed({va_r.px[15], va_r.px});
        e2_r[1] <= $signed({vc_r.py[15], vc_r.py}) - $signed({va_r.py[15], va_r.py});
        e2_r[2] <= $signed({vc_r.pz[15], vc_r.pz}) - $signed({va_r.pz[15], va_r.pz});
        du1_r   <= $signed({vb_r.tu[15], vb_r.tu}) - $signed({va_r.tu[15], va_r.tu});
        dv1_r   <= $signed({vb_r.tv[15], vb_r.tv}) - $signed({va_r.tv[15], va_r.tv});
        du2_r   <= $signed({vc_r.tu[15], vc_r.tu}) - $signed({va_r.tu[15], va_r.tu});
        dv2_r   <= $signed({vc_r.tv[15], vc_r.tv}) - $signed({va_r.tv[15], va_r.tv});
      end
      S_T_MDET: begin
        p0_r <= du1_r * dv2_r;
        p1_r <= du2_r * dv1_r;
      end
      S_T_DET: det_r <= det_nxt;
      S_T_MNUM: begin
        p0_r <= dv2_r * e1_r[k_r];
        p1_r <= dv1_r * e2_r[k_r];
      end
      S_T_NUM: begin
        neg_r     <= num_nxt[34] ^ det_r[34];
        div_rem_r <= '0;
        div_quo_r <= {1'b0, an, 21'b0} + {22'b0, ad};
        div_den_r <= {ad, 1'b0};
      end
      S_DIV: begin
        div_rem_r <= rem_ge ? (rem_sh - {1'b0, div_den_r}) : rem_sh;
        div_quo_r <= {div_quo_r[55:0], rem_ge};
      end
      S_T_QUO: t_r[k_r] <= t_sat;
      S_R_CAP: begin
        sg_r[0] <= sum_rdata.sx[31];
        sg_r[1] <= sum_rdata.sy[31];
        sg_r[2] <= sum_rdata.sz[31];
        m_r[0]  <= sum_rdata.sx[31] ? (~sum_rdata.sx + 32'd1) : sum_rdata.sx;
        m_r[1]  <= sum_rdata.sy[31] ? (~sum_rdata.sy + 32'd1) : sum_rdata.sy;
        m_r[2]  <= sum_rdata.sz[31] ? (~sum_rdata.sz + 32'd1) : sum_rdata.sz;
      end
      S_R_NORM: begin
        l2_r <= '0;
        if ((m_r[0][31:30] | m_r[1][31:30] | m_r[2][31:30]) == 2'b00) begin
          m_r[0] <= {m_r[0][30:0], 1'b0};
          m_r[1] <= {m_r[1][30:0], 1'b0};
          m_r[2] <= {m_r[2][30:0], 1'b0};
        end
      end
      S_R_SQ: begin
        if (j_r != 2'd0) begin
          l2_r <= l2_r + sq_r;
        end
        sq_r <= m_r[sq_idx] * m_r[sq_idx];
        sx_r   <= l2_r + sq_r;
        sres_r <= '0;
        sbit_r <= 64'h4000_0000_0000_0000;
      end
      S_R_SQRT: begin
        if (sq_ge) begin
          sx_r   <= sx_r - sq_try;
          sres_r <= {1'b0, sres_r[63:1]} + sbit_r;
        end else begin
          sres_r <= {1'b0, sres_r[63:1]};
        end
        sbit_r <= {2'b00, sbit_r[63:2]};
      end
      S_R_LD: begin
        div_rem_r <= '0;
        div_quo_r <= {10'b0, m_r[k_r], 15'b0} + {24'b0, sres_r[32:0]};
        div_den_r <= {2'b0, sres_r[32:0], 1'b0};
        res_zl_r  <= 1'b0;
      end
      S_R_QUO: res_r[k_r] <= sg_r[k_r] ? $signed(~q16 + 16'd1) : $signed(q16);
      S_R_OUT: begin
        if (out_free) begin
          o_x_r  <= res_r[0];
          o_y_r  <= res_r[1];
          o_z_r  <= res_r[2];
          o_zl_r <= res_zl_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tangent_x   = o_x_r;
  assign out_ch.tangent_y   = o_y_r;
  assign out_ch.tangent_z   = o_z_r;
  assign out_ch.zero_length = o_zl_r;

  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_length |->
      out_ch.tangent_x == 16'sd0 && out_ch.tangent_y == 16'sd0 && out_ch.tangent_z == 16'sd0)
    else $error("zero_length result carries a nonzero vector");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      out_ch.tangent_x <= 16'sd16384 && out_ch.tangent_x >= -16'sd16384 &&
      out_ch.tangent_y <= 16'sd16384 && out_ch.tangent_y >= -16'sd16384 &&
      out_ch.tangent_z <= 16'sd16384 && out_ch.tangent_z >= -16'sd16384)
    else $error("normalized component out of range");

  a_sqrt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_R_LD |-> sres_r != '0)
    else $error("divider loaded with zero length");

  a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_T_NUM |-> det_r != '0)
    else $error("divider loaded with zero determinant");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |=> $past(clr_addr_r) == AW'(VERTEX_DEPTH - 1) || state_r == S_CLR)
    else $error("clearing pass left early");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the per-vertex tangent accumulator.
module tb;
  import tta_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned DEPTH = 4096;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [1:0]         kind;
    logic [11:0]        vidx;
    logic signed [15:0] px, py, pz, tu, tv;
    logic [11:0]        ca, cb, cc;
  } request_t;

  typedef struct {
    logic signed [15:0] tx, ty, tz;
    logic               zl;
  } tangent_t;

  class tangent_scoreboard;
    int                 pos[DEPTH][3];
    int                 uv[DEPTH][2];
    int                 sum[DEPTH][3];
    tangent_t           pending_q[$];
    int                 mismatches = 0;
    int                 checked = 0;
    int                 zero_reads = 0;
    int                 tris = 0;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        for (int k = 0; k < 3; k++) begin
          pos[i][k] = 0;
          sum[i][k] = 0;
        end
        uv[i][0] = 0;
        uv[i][1] = 0;
      end
    endfunction

    function int sat_add(int a, int b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > 64'sd2147483647) return 32'h7fffffff;
      if (s < -64'sd2147483648) return 32'h80000000;
      return int'(s);
    endfunction

    function int tangent_quotient(longint n, longint d);
      longint unsigned an, ad, q;
      bit neg;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = ((an << 21) + ad) / (2 * ad);
      neg = (n < 0) != (d < 0);
      if (neg) begin
        if (q >= 64'h80000000) return 32'h80000000;
        return int'(-longint'(q));
      end
      if (q > 64'h7fffffff) return 32'h7fffffff;
      return int'(q);
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void add_triangle(int a, int b, int c);
      longint e1[3], e2[3], du1, dv1, du2, dv2, det;
      int t[3];
      int corner[3];
      for (int k = 0; k < 3; k++) begin
        e1[k] = longint'(pos[b][k]) - pos[a][k];
        e2[k] = longint'(pos[c][k]) - pos[a][k];
      end
      du1 = longint'(uv[b][0]) - uv[a][0];
      dv1 = longint'(uv[b][1]) - uv[a][1];
      du2 = longint'(uv[c][0]) - uv[a][0];
      dv2 = longint'(uv[c][1]) - uv[a][1];
      det = du1 * dv2 - du2 * dv1;
      if (det == 0) return;
      tris++;
      for (int k = 0; k < 3; k++) t[k] = tangent_quotient(dv2 * e1[k] - dv1 * e2[k], det);
      corner[0] = a;
      corner[1] = b;
      corner[2] = c;
      for (int j = 0; j < 3; j++)
        for (int k = 0; k < 3; k++) sum[corner[j]][k] = sat_add(sum[corner[j]][k], t[k]);
    endfunction

    function tangent_t unit_tangent(int v);
      tangent_t o;
      longint s[3];
      longint unsigned m[3], mx, l2, r, q;
      o.tx = 0;
      o.ty = 0;
      o.tz = 0;
      o.zl = 1;
      for (int k = 0; k < 3; k++) begin
        s[k] = sum[v][k];
        m[k] = s[k] < 0 ? -s[k] : s[k];
      end
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx == 0) return o;
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int k = 0; k < 3; k++) m[k] <<= 1;
      end
      l2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = int_sqrt(l2);
      for (int k = 0; k < 3; k++) begin
        q = (m[k] * 32768 + r) / (2 * r);
        if (s[k] < 0) q = -q;
        m[k] = q;
      end
      o.tx = m[0][15:0];
      o.ty = m[1][15:0];
      o.tz = m[2][15:0];
      o.zl = 0;
      return o;
    endfunction

    function void note_request(request_t rq);
      case (rq.kind)
        REQ_WRITE: begin
          pos[rq.vidx][0] = int'(rq.px);
          pos[rq.vidx][1] = int'(rq.py);
          pos[rq.vidx][2] = int'(rq.pz);
          uv[rq.vidx][0] = int'(rq.tu);
          uv[rq.vidx][1] = int'(rq.tv);
          for (int k = 0; k < 3; k++) sum[rq.vidx][k] = 0;
        end
        REQ_TRI: add_triangle(int'(rq.ca), int'(rq.cb), int'(rq.cc));
        REQ_READ: pending_q.push_back(unit_tangent(int'(rq.vidx)));
        default: ;
      endcase
    endfunction

    function void check_result(tangent_t got);
      tangent_t exp_t;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result tx=%0d ty=%0d tz=%0d zl=%0d",
                                       got.tx, got.ty, got.tz, got.zl);
        return;
      end
      exp_t = pending_q.pop_front();
      checked++;
      if (exp_t.zl) zero_reads++;
      if (got.tx !== exp_t.tx || got.ty !== exp_t.ty || got.tz !== exp_t.tz ||
          got.zl !== exp_t.zl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d %0d %0d zl=%0d, actual %0d %0d %0d zl=%0d",
                   exp_t.tx, exp_t.ty, exp_t.tz, exp_t.zl, got.tx, got.ty, got.tz, got.zl);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  longint cycles = 0;
  bit     no_stall = 0;
  int     stall_left = 0;

  tta_in_if  in_ch();
  tta_out_if out_ch();

  triangle_tangent_accumulator i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  tangent_scoreboard sb = new();
  int written_q[$];
  bit written[DEPTH];
  int work_set[$];

  initial begin
    in_ch.valid = 0;
    in_ch.req_type = REQ_NONE;
    in_ch.vertex_index = 0;
    in_ch.pos_x = 0;
    in_ch.pos_y = 0;
    in_ch.pos_z = 0;
    in_ch.tex_u = 0;
    in_ch.tex_v = 0;
    in_ch.corner_a = 0;
    in_ch.corner_b = 0;
    in_ch.corner_c = 0;
    out_ch.ready = 0;
  end

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    tangent_t got;
    if (out_ch.valid && out_ch.ready) begin
      got.tx = out_ch.tangent_x;
      got.ty = out_ch.tangent_y;
      got.tz = out_ch.tangent_z;
      got.zl = out_ch.zero_length;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
      if ($urandom_range(0, 499) == 0) no_stall <= !no_stall;
      if (!no_stall && $urandom_range(0, 9) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                  : $urandom_range(1, 4);
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send(request_t rq, bit gaps);
    int g;
    in_ch.valid        <= 1;
    in_ch.req_type     <= rq.kind;
    in_ch.vertex_index <= rq.vidx;
    in_ch.pos_x        <= rq.px;
    in_ch.pos_y        <= rq.py;
    in_ch.pos_z        <= rq.pz;
    in_ch.tex_u        <= rq.tu;
    in_ch.tex_v        <= rq.tv;
    in_ch.corner_a     <= rq.ca;
    in_ch.corner_b     <= rq.cb;
    in_ch.corner_c     <= rq.cc;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(rq);
    if (rq.kind == REQ_WRITE && !written[rq.vidx]) begin
      written[rq.vidx] = 1;
      written_q.push_back(int'(rq.vidx));
    end
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic request_t noise_req();
    request_t rq;
    rq.kind = REQ_NONE;
    rq.vidx = 12'($urandom);
    rq.px = 16'($urandom);
    rq.py = 16'($urandom);
    rq.pz = 16'($urandom);
    rq.tu = 16'($urandom);
    rq.tv = 16'($urandom);
    rq.ca = 12'($urandom);
    rq.cb = 12'($urandom);
    rq.cc = 12'($urandom);
    return rq;
  endfunction

  function automatic request_t write_req(int v, int x, int y, int z, int u, int w);
    request_t rq;
    rq = noise_req();
    rq.kind = REQ_WRITE;
    rq.vidx = 12'(v);
    rq.px = 16'(x);
    rq.py = 16'(y);
    rq.pz = 16'(z);
    rq.tu = 16'(u);
    rq.tv = 16'(w);
    return rq;
  endfunction

  function automatic request_t tri_req(int a, int b, int c);
    request_t rq;
    rq = noise_req();
    rq.kind = REQ_TRI;
    rq.ca = 12'(a);
    rq.cb = 12'(b);
    rq.cc = 12'(c);
    return rq;
  endfunction

  function automatic request_t read_req(int v);
    request_t rq;
    rq = noise_req();
    rq.kind = REQ_READ;
    rq.vidx = 12'(v);
    return rq;
  endfunction

  function automatic int small_or_full();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                       : $urandom_range(0, 2047) - 1024;
  endfunction

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int p;
    int a;
    int b;
    int c;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    send(write_req(0, 0, 0, 0, 0, 0), 0);
    send(write_req(4095, 32767, 32767, 32767, 1, 0), 0);
    send(write_req(2730, -32768, -32768, -32768, 0, 1), 0);
    send(tri_req(0, 4095, 2730), 0);
    send(tri_req(0, 4095, 2730), 1);
    send(read_req(0), 0);
    send(read_req(4095), 0);
    send(read_req(1365), 0);
    send(write_req(1365, 100, -200, 300, 32767, -32768), 0);
    send(write_req(7, -5, 9, 1, 32767, -32768), 0);
    send(tri_req(1365, 7, 0), 0);
    send(read_req(1365), 0);
    send(tri_req(7, 7, 1365), 0);
    send(tri_req(1365, 0, 0), 0);
    send(noise_req(), 0);
    send(write_req(200, 256, 0, 0, 0, 0), 0);
    send(write_req(201, 0, 256, 0, 4096, 0), 0);
    send(write_req(202, 0, 0, 256, 0, 4096), 0);
    send(tri_req(200, 201, 202), 0);
    send(read_req(201), 0);
    send(write_req(0, 1, 1, 1, -32768, 32767), 0);
    send(read_req(0), 1);
    send(read_req(2730), 0);

    for (int i = 0; i < 24; i++) work_set.push_back($urandom_range(0, DEPTH - 1));
    work_set.push_back(0);
    work_set.push_back(DEPTH - 1);

    for (int i = 0; i < 1250; i++) begin
      if (i == 600) begin
        in_ch.valid <= 0;
        wait_drained();
        @(posedge clk);
      end
      p = $urandom_range(0, 99);
      if (p < 25) begin
        a = ($urandom_range(0, 9) < 7) ? work_set[$urandom_range(0, work_set.size() - 1)]
                                       : $urandom_range(0, DEPTH - 1);
        send(write_req(a, small_or_full(), small_or_full(), small_or_full(),
                       small_or_full(), small_or_full()), 1);
      end else if (p < 65) begin
        a = written_q[$urandom_range(0, written_q.size() - 1)];
        b = written_q[$urandom_range(0, written_q.size() - 1)];
        c = written_q[$urandom_range(0, written_q.size() - 1)];
        send(tri_req(a, b, c), 1);
      end else if (p < 95) begin
        a = ($urandom_range(0, 9) < 8) ? written_q[$urandom_range(0, written_q.size() - 1)]
                                       : $urandom_range(0, DEPTH - 1);
        send(read_req(a), 1);
      end else begin
        send(noise_req(), 1);
      end
    end
    in_ch.valid <= 0;

    wait_drained();
    repeat (400) @(posedge clk);
    $display("covered %0d reads (%0d of zero length) and %0d triangles with nonzero det",
             sb.checked, sb.zero_reads, sb.tris);
    $display("mismatches: %0d, results left unseen: %0d", sb.mismatches, sb.pending_q.size());
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
